// ===== rtl/core/gdps_pkg.sv =====
// Shared codes, constants and types for the gate driver power sequencer.
package gdps_pkg;

  localparam logic [2:0] ST_RESET   = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_PUP     = 3'd2;
  localparam logic [2:0] ST_PFAULT  = 3'd3;
  localparam logic [2:0] ST_POWERED = 3'd4;
  localparam logic [2:0] ST_SON     = 3'd5;
  localparam logic [2:0] ST_SOFF    = 3'd6;
  localparam logic [2:0] ST_SFAULT  = 3'd7;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_HALT  = 2'd2;
  localparam logic [1:0] ACT_RESET = 2'd3;

  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_PUP      = 4'd1;
  localparam logic [3:0] EV_CUR_HIGH = 4'd2;
  localparam logic [3:0] EV_TIMEOUT  = 4'd3;
  localparam logic [3:0] EV_POWERED  = 4'd4;
  localparam logic [3:0] EV_RETRY    = 4'd5;
  localparam logic [3:0] EV_UP_LOW   = 4'd6;
  localparam logic [3:0] EV_VCC_LOW  = 4'd7;
  localparam logic [3:0] EV_SYNC_ON  = 4'd8;
  localparam logic [3:0] EV_SYNC_OFF = 4'd9;
  localparam logic [3:0] EV_E_STOP   = 4'd10;
  localparam logic [3:0] EV_F_STOP   = 4'd11;

  localparam logic [2:0] CFG_CURRENT_MAX = 3'd0;
  localparam logic [2:0] CFG_UPSTREAM    = 3'd1;
  localparam logic [2:0] CFG_VCC         = 3'd2;
  localparam logic [2:0] CFG_PUP_TIMEOUT = 3'd3;
  localparam logic [2:0] CFG_RETRY_DELAY = 3'd4;
  localparam logic [2:0] CFG_RETRY_LIMIT = 3'd5;
  localparam logic [2:0] CFG_HOLD_ON     = 3'd6;
  localparam logic [2:0] CFG_HOLD_OFF    = 3'd7;

  localparam logic [31:0] POWERED_HOLD_MS = 32'd100;
  localparam logic [31:0] SYNC_SETTLE_MS  = 32'd50;
  localparam logic [31:0] SFAULT_HOLD_MS  = 32'd500;

  localparam logic [7:0] TALLY_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] supply_current_max_ma;
    logic [15:0] upstream_min_mv;
    logic [15:0] driver_vcc_min_mv;
    logic [31:0] pup_limit_ms;
    logic [31:0] retry_delay_ms;
    logic [7:0]  fault_retry_limit;
    logic [31:0] sync_hold_on_ms;
    logic [31:0] sync_hold_off_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic [1:0]         action;
    logic signed [16:0] supply_current_ma;
    logic signed [16:0] upstream_voltage_mv;
    logic signed [16:0] driver_vcc_mv;
    logic               sync_e_valid;
    logic               sync_f_valid;
  } tick_t;

  typedef struct packed {
    logic [2:0] fsm_state;
    logic [3:0] event_code;
    logic       event_valid;
    logic       power_enable;
    logic       drive_a_enable;
    logic       drive_b_enable;
  } status_t;

endpackage

// ===== rtl/core/gdps_tick_if.sv =====
// Request channel carrying one sequencer tick.
interface gdps_tick_if;
  logic               valid;
  logic               ready;
  logic [31:0]        time_ms;
  logic [1:0]         action;
  logic signed [16:0] supply_current_ma;
  logic signed [16:0] upstream_voltage_mv;
  logic signed [16:0] driver_vcc_mv;
  logic               sync_e_valid;
  logic               sync_f_valid;

  modport source (
    output valid, time_ms, action, supply_current_ma, upstream_voltage_mv,
           driver_vcc_mv, sync_e_valid, sync_f_valid,
    input  ready
  );
  modport sink (
    input  valid, time_ms, action, supply_current_ma, upstream_voltage_mv,
           driver_vcc_mv, sync_e_valid, sync_f_valid,
    output ready
  );
endinterface

// ===== rtl/core/gdps_status_if.sv =====
// Result channel carrying the sequencer status for one tick.
interface gdps_status_if;
  logic       valid;
  logic       ready;
  logic [2:0] fsm_state;
  logic [3:0] event_code;
  logic       event_valid;
  logic       power_enable;
  logic       drive_a_enable;
  logic       drive_b_enable;

  modport source (
    output valid, fsm_state, event_code, event_valid, power_enable,
           drive_a_enable, drive_b_enable,
    input  ready
  );
  modport sink (
    input  valid, fsm_state, event_code, event_valid, power_enable,
           drive_a_enable, drive_b_enable,
    output ready
  );
endinterface

// ===== rtl/core/gate_driver_power_sequencer_core.sv =====
// Top level of the gate driver power sequencer: input stage, configuration registers, sequencer and status register.
//
//   channel   dir   handshake          payload
//   tick      sink  valid/ready        time, command, three supply readings, sync flags
//   status    src   valid/ready        state, event code/flag, power and drive enables
//   cfg       sink  cfg_we (no wait)   cfg_index, cfg_data
//
// One tick per cycle while status is not stalled; a request is registered in the input stage and then in the status
// register before it shows up as status. The rate is set by the sequencer registers, which take a new state per tick.
// Synchronous reset puts the sequencer in the reset state with a zero tally.
// A stalled status holds its register; one more request is taken into the input stage.
module gate_driver_power_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  gdps_tick_if.sink   tick,
  gdps_status_if.source status
);
  import gdps_pkg::*;

  cfg_t    cfg;
  tick_t   stage;
  logic    stage_valid;
  status_t seq_status;
  status_t result;
  logic    result_valid;
  logic    advance;
  logic    fire;
  logic    take;
  logic [2:0] seq_state;

  assign advance    = !result_valid || status.ready;
  assign fire       = stage_valid && advance;
  assign tick.ready = !stage_valid || advance;
  assign take       = tick.valid && tick.ready;

  gdps_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  gdps_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (stage),
    .cfg    (cfg),
    .status (seq_status),
    .state  (seq_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage.time_ms             <= tick.time_ms;
      stage.action              <= tick.action;
      stage.supply_current_ma   <= tick.supply_current_ma;
      stage.upstream_voltage_mv <= tick.upstream_voltage_mv;
      stage.driver_vcc_mv       <= tick.driver_vcc_mv;
      stage.sync_e_valid        <= tick.sync_e_valid;
      stage.sync_f_valid        <= tick.sync_f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= seq_status;
    end
  end

  assign status.valid          = result_valid;
  assign status.fsm_state      = result.fsm_state;
  assign status.event_code     = result.event_code;
  assign status.event_valid    = result.event_valid;
  assign status.power_enable   = result.power_enable;
  assign status.drive_a_enable = result.drive_a_enable;
  assign status.drive_b_enable = result.drive_b_enable;

  // A halt request always leaves the sequencer halted.
  a_halt_cmd: assert property (@(posedge clk) disable iff (rst)
    fire && stage.action == ACT_HALT |=> seq_state == ST_HALT)
    else $error("halt request did not reach the halt state");

  // The reported state matches the sequencer registers once it is issued.
  a_state_track: assert property (@(posedge clk) disable iff (rst)
    fire |=> result.fsm_state == seq_state)
    else $error("status state differs from sequencer state");

  a_drive_only_son: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.drive_a_enable || result.drive_b_enable)
      |-> result.fsm_state == ST_SON && result.power_enable)
    else $error("drive enabled outside sync-on");

  a_event_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.event_valid == (result.event_code != EV_NONE))
    else $error("event flag disagrees with event code");

endmodule

// ===== rtl/core/gdps_cfg_regs.sv =====
// Configuration register bank of the power sequencer.
module gdps_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [2:0]    index,
  input  logic [31:0]   data,
  output gdps_pkg::cfg_t cfg
);
  import gdps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.supply_current_max_ma <= 16'd1000;
      cfg.upstream_min_mv       <= 16'd10000;
      cfg.driver_vcc_min_mv     <= 16'd4500;
      cfg.pup_limit_ms          <= 32'd500;
      cfg.retry_delay_ms        <= 32'd1000;
      cfg.fault_retry_limit     <= 8'd0;
      cfg.sync_hold_on_ms       <= 32'd1000;
      cfg.sync_hold_off_ms      <= 32'd1000;
    end else if (we) begin
      case (index)
        CFG_CURRENT_MAX: cfg.supply_current_max_ma <= data[15:0];
        CFG_UPSTREAM:    cfg.upstream_min_mv       <= data[15:0];
        CFG_VCC:         cfg.driver_vcc_min_mv     <= data[15:0];
        CFG_PUP_TIMEOUT: cfg.pup_limit_ms          <= data;
        CFG_RETRY_DELAY: cfg.retry_delay_ms        <= data;
        CFG_RETRY_LIMIT: cfg.fault_retry_limit     <= data[7:0];
        CFG_HOLD_ON:     cfg.sync_hold_on_ms       <= data;
        CFG_HOLD_OFF:    cfg.sync_hold_off_ms      <= data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/gdps_seq.sv =====
// Sequencer state, entry time and fault tally with the per-tick transition logic.
module gdps_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  gdps_pkg::tick_t  item,
  input  gdps_pkg::cfg_t   cfg,
  output gdps_pkg::status_t status,
  output logic [2:0]       state
);
  import gdps_pkg::*;

  logic [31:0] entry_time;
  logic [7:0]  tally;

  logic [2:0]  state_next;
  logic [7:0]  tally_next;
  logic [3:0]  ev;
  logic        go_to;
  logic [31:0] el;
  logic        cur_high;
  logic        up_low;
  logic        vcc_low;
  logic        good;
  logic        common;
  logic        retry_ok;

  // Negative readings are invalid: never too high, always low; a negative voltage is never good.
  always_comb begin
    el       = item.time_ms - entry_time;
    cur_high = !item.supply_current_ma[16] &&
               (item.supply_current_ma[15:0] >= cfg.supply_current_max_ma);
    up_low   = item.upstream_voltage_mv[16] ||
               (item.upstream_voltage_mv[15:0] < cfg.upstream_min_mv);
    vcc_low  = item.driver_vcc_mv[16] ||
               (item.driver_vcc_mv[15:0] < cfg.driver_vcc_min_mv);
    good     = !item.upstream_voltage_mv[16] && !item.driver_vcc_mv[16] &&
               (item.upstream_voltage_mv[15:0] > cfg.upstream_min_mv) &&
               (item.driver_vcc_mv[15:0] > cfg.driver_vcc_min_mv) && !cur_high;
    common   = (state == ST_POWERED || state == ST_SON ||
                state == ST_SOFF || state == ST_SFAULT) &&
               (cur_high || up_low || vcc_low);
    retry_ok = (cfg.fault_retry_limit == 8'd0) || (tally < cfg.fault_retry_limit);
  end

  always_comb begin
    go_to      = 1'b0;
    state_next = state;
    ev         = EV_NONE;
    if (item.action == ACT_RUN && state != ST_PUP) begin
      go_to = 1'b1; state_next = ST_PUP; ev = EV_PUP;
    end else if (item.action == ACT_HALT && state != ST_HALT) begin
      go_to = 1'b1; state_next = ST_HALT;
    end else if (item.action == ACT_RESET && state != ST_RESET) begin
      go_to = 1'b1; state_next = ST_RESET;
    end else if (common) begin
      go_to      = 1'b1;
      state_next = ST_PFAULT;
      ev         = cur_high ? EV_CUR_HIGH : (up_low ? EV_UP_LOW : EV_VCC_LOW);
    end else begin
      case (state)
        ST_PUP: begin
          if (cur_high) begin
            go_to = 1'b1; state_next = ST_PFAULT; ev = EV_CUR_HIGH;
          end else if (el >= cfg.pup_limit_ms) begin
            go_to = 1'b1; state_next = ST_PFAULT; ev = EV_TIMEOUT;
          end else if (good) begin
            go_to = 1'b1; state_next = ST_POWERED; ev = EV_POWERED;
          end
        end
        ST_PFAULT: begin
          if (el > cfg.retry_delay_ms && retry_ok) begin
            go_to = 1'b1; state_next = ST_PUP; ev = EV_RETRY;
          end
        end
        ST_POWERED: begin
          if (el > POWERED_HOLD_MS) begin
            go_to = 1'b1; state_next = ST_SON; ev = EV_SYNC_ON;
          end
        end
        ST_SON: begin
          if (el > SYNC_SETTLE_MS && !item.sync_e_valid) begin
            go_to = 1'b1; state_next = ST_SFAULT; ev = EV_E_STOP;
          end else if (el > SYNC_SETTLE_MS && !item.sync_f_valid) begin
            go_to = 1'b1; state_next = ST_SFAULT; ev = EV_F_STOP;
          end else if (el > cfg.sync_hold_on_ms) begin
            go_to = 1'b1; state_next = ST_SOFF; ev = EV_SYNC_OFF;
          end
        end
        ST_SOFF: begin
          if (el > cfg.sync_hold_off_ms) begin
            go_to = 1'b1; state_next = ST_SON; ev = EV_SYNC_ON;
          end
        end
        ST_SFAULT: begin
          if (el > SFAULT_HOLD_MS) begin
            go_to = 1'b1; state_next = ST_SON; ev = EV_SYNC_ON;
          end
        end
        default: ;
      endcase
    end

    tally_next = tally;
    if (go_to) begin
      if (state_next == ST_RESET) begin
        tally_next = 8'd0;
      end else if (state_next == ST_PFAULT && tally != TALLY_MAX) begin
        tally_next = tally + 8'd1;
      end
    end
  end

  always_comb begin
    status.fsm_state      = state_next;
    status.event_code     = ev;
    status.event_valid    = (ev != EV_NONE);
    status.power_enable   = (state_next >= ST_POWERED) || (state_next == ST_PUP);
    status.drive_a_enable = (state_next == ST_SON);
    status.drive_b_enable = (state_next == ST_SON);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RESET;
      entry_time <= 32'd0;
      tally      <= 8'd0;
    end else if (fire) begin
      state <= state_next;
      tally <= tally_next;
      if (go_to) begin
        entry_time <= item.time_ms;
      end
    end
  end

endmodule

// ===== test/gate_driver_power_sequencer_core_tb.sv =====
// Self-checking testbench for the gate driver power sequencer core.
`timescale 1ns / 100ps

module gate_driver_power_sequencer_core_tb;
  import gdps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int GOOD_CUR = 100;
  localparam int GOOD_UP = 12000;
  localparam int GOOD_VCC = 5000;

  // Field order: current max, upstream min, vcc min, power-up timeout, retry delay,
  // retry limit, hold on, hold off.
  localparam cfg_t CFG_AT_RESET = '{16'd1000, 16'd10000, 16'd4500, 32'd500, 32'd1000,
                                    8'd0, 32'd1000, 32'd1000};
  localparam cfg_t CFG_ALL_LOW = '{16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0, 32'd0, 32'd0};
  localparam cfg_t CFG_ALL_HIGH = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
  localparam cfg_t CFG_FAULT_STORM = '{16'd1000, 16'd10000, 16'd4500, 32'd500, 32'd0,
                                       8'd255, 32'd1000, 32'd1000};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  gdps_tick_if   tick_ch ();
  gdps_status_if status_ch ();

  gate_driver_power_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .status    (status_ch)
  );

  always #5 clk = ~clk;

  // Sequencer model state and its copy of the configuration.
  cfg_t        cfg_model;
  logic [2:0]  seq_q;
  logic [31:0] entry_ms;
  logic [7:0]  fault_tally;

  tick_t   pending_ticks[$];
  status_t expected_status[$];

  tick_t       offered;
  logic        offering;
  int          gap_left;
  int          stall_left;
  int          tx_gap_max;
  int          rx_stall_max;
  logic        receiver_hold;
  logic [31:0] stim_ms;
  status_t     want;
  int          status_count;
  int          mismatch_count;
  int          cycle_count;

  function automatic status_t advance_sequencer(input tick_t t);
    int          cur, up, vcc, cmax, umin, vmin;
    logic [31:0] el;
    logic        cur_high, up_low, vcc_low, good, supply_bad;
    logic [2:0]  nxt;
    logic [3:0]  ev;
    status_t     s;
    cur = $signed(t.supply_current_ma);
    up = $signed(t.upstream_voltage_mv);
    vcc = $signed(t.driver_vcc_mv);
    cmax = cfg_model.supply_current_max_ma;
    umin = cfg_model.upstream_min_mv;
    vmin = cfg_model.driver_vcc_min_mv;
    el = t.time_ms - entry_ms;
    // A negative reading is invalid: never too high, always too low.
    cur_high = (cur >= 0) && (cur >= cmax);
    up_low = (up < 0) || (up < umin);
    vcc_low = (vcc < 0) || (vcc < vmin);
    good = (up > umin) && (vcc > vmin) && !cur_high;
    supply_bad = (seq_q >= ST_POWERED) && (cur_high || up_low || vcc_low);
    nxt = seq_q;
    ev = EV_NONE;
    if (t.action == ACT_RUN && seq_q != ST_PUP) begin
      nxt = ST_PUP;
      ev = EV_PUP;
    end else if (t.action == ACT_HALT && seq_q != ST_HALT) begin
      nxt = ST_HALT;
    end else if (t.action == ACT_RESET && seq_q != ST_RESET) begin
      nxt = ST_RESET;
    end else if (supply_bad) begin
      nxt = ST_PFAULT;
      ev = cur_high ? EV_CUR_HIGH : (up_low ? EV_UP_LOW : EV_VCC_LOW);
    end else begin
      case (seq_q)
        ST_PUP: begin
          if (cur_high) begin
            nxt = ST_PFAULT;
            ev = EV_CUR_HIGH;
          end else if (el >= cfg_model.pup_limit_ms) begin
            nxt = ST_PFAULT;
            ev = EV_TIMEOUT;
          end else if (good) begin
            nxt = ST_POWERED;
            ev = EV_POWERED;
          end
        end
        ST_PFAULT: begin
          if (el > cfg_model.retry_delay_ms && (cfg_model.fault_retry_limit == '0 ||
              fault_tally < cfg_model.fault_retry_limit)) begin
            nxt = ST_PUP;
            ev = EV_RETRY;
          end
        end
        ST_POWERED: begin
          if (el > POWERED_HOLD_MS) begin
            nxt = ST_SON;
            ev = EV_SYNC_ON;
          end
        end
        ST_SON: begin
          if (el > SYNC_SETTLE_MS && !t.sync_e_valid) begin
            nxt = ST_SFAULT;
            ev = EV_E_STOP;
          end else if (el > SYNC_SETTLE_MS && !t.sync_f_valid) begin
            nxt = ST_SFAULT;
            ev = EV_F_STOP;
          end else if (el > cfg_model.sync_hold_on_ms) begin
            nxt = ST_SOFF;
            ev = EV_SYNC_OFF;
          end
        end
        ST_SOFF: begin
          if (el > cfg_model.sync_hold_off_ms) begin
            nxt = ST_SON;
            ev = EV_SYNC_ON;
          end
        end
        ST_SFAULT: begin
          if (el > SFAULT_HOLD_MS) begin
            nxt = ST_SON;
            ev = EV_SYNC_ON;
          end
        end
        default: begin
        end
      endcase
    end
    // No transition targets its own state, so a change of state marks an entry.
    if (nxt != seq_q) begin
      entry_ms = t.time_ms;
      if (nxt == ST_RESET) fault_tally = '0;
      else if (nxt == ST_PFAULT && fault_tally != TALLY_MAX) fault_tally = fault_tally + 8'd1;
    end
    seq_q = nxt;
    s.fsm_state = nxt;
    s.event_code = ev;
    s.event_valid = (ev != EV_NONE);
    s.power_enable = (nxt == ST_PUP) || (nxt >= ST_POWERED);
    s.drive_a_enable = (nxt == ST_SON);
    s.drive_b_enable = (nxt == ST_SON);
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] expv);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] status %0d: %s is %0d, expected %0d", $time, status_count, what, got,
               expv);
  endtask

  task automatic queue_tick(input logic [31:0] at_ms, input logic [1:0] act,
                            input int cur, input int up, input int vcc,
                            input logic e_ok, input logic f_ok);
    tick_t t;
    t.time_ms = at_ms;
    t.action = act;
    t.supply_current_ma = cur[16:0];
    t.upstream_voltage_mv = up[16:0];
    t.driver_vcc_mv = vcc[16:0];
    t.sync_e_valid = e_ok;
    t.sync_f_valid = f_ok;
    pending_ticks.push_back(t);
  endtask

  function automatic int good_current();
    int hi;
    hi = cfg_model.supply_current_max_ma;
    if (hi == 0 || $urandom_range(0, 9) == 0) return -int'($urandom_range(1, 65536));
    return $urandom_range(0, hi - 1);
  endfunction

  function automatic int good_voltage(input int min_mv);
    if (min_mv >= 65535) return 65535;
    return $urandom_range(min_mv + 1, 65535);
  endfunction

  function automatic int noisy_reading(input int threshold);
    logic [16:0] raw;
    raw = 17'($urandom);
    case ($urandom_range(0, 3))
      0: return threshold;
      1: return threshold - 1;
      2: return -int'($urandom_range(1, 65536));
      default: return $signed(raw);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.supply_current_max_ma = 16'($urandom_range(500, 60000));
    c.upstream_min_mv = 16'($urandom_range(1000, 50000));
    c.driver_vcc_min_mv = 16'($urandom_range(1000, 50000));
    c.pup_limit_ms = $urandom_range(50, 1500);
    c.retry_delay_ms = $urandom_range(0, 1500);
    c.fault_retry_limit = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
    c.sync_hold_on_ms = $urandom_range(0, 1500);
    c.sync_hold_off_ms = $urandom_range(0, 1500);
    return c;
  endfunction

  // Mostly well-formed runs with supplies in range, with faults and commands mixed in.
  task automatic queue_random_ticks(input int count);
    int         r, cur, up, vcc;
    logic [1:0] act;
    logic       e_ok, f_ok;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) stim_ms += $urandom_range(0, 60);
      else if (r < 80) stim_ms += $urandom_range(0, 700);
      else if (r < 96) stim_ms += $urandom_range(0, 2500);
      else stim_ms = $urandom;
      r = $urandom_range(0, 99);
      if (r < 82) act = ACT_NONE;
      else if (r < 90) act = ACT_RUN;
      else if (r < 94) act = ACT_HALT;
      else if (r < 97) act = ACT_RESET;
      else act = 2'($urandom_range(0, 3));
      cur = good_current();
      up = good_voltage(cfg_model.upstream_min_mv);
      vcc = good_voltage(cfg_model.driver_vcc_min_mv);
      if ($urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 2))
          0: cur = noisy_reading(cfg_model.supply_current_max_ma);
          1: up = noisy_reading(cfg_model.upstream_min_mv);
          default: vcc = noisy_reading(cfg_model.driver_vcc_min_mv);
        endcase
      end
      e_ok = 1'b1;
      f_ok = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        e_ok = 1'($urandom);
        f_ok = 1'($urandom);
      end
      queue_tick(stim_ms, act, cur, up, vcc, e_ok, f_ok);
    end
  endtask

  // With no retry delay and a high current every tick, power-up and power-fault
  // alternate until the tally reaches the retry limit and saturates there.
  task automatic queue_fault_storm(input int count);
    logic [1:0] act;
    stim_ms += 32'd1;
    queue_tick(stim_ms, ACT_RUN, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    for (int n = 0; n < count; n++) begin
      stim_ms += $urandom_range(1, 50);
      act = ($urandom_range(0, 9) == 0) ? ACT_RUN : ACT_NONE;
      queue_tick(stim_ms, act, $urandom_range(cfg_model.supply_current_max_ma, 65535),
                 noisy_reading(cfg_model.upstream_min_mv),
                 noisy_reading(cfg_model.driver_vcc_min_mv), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_CURRENT_MAX, 32'(c.supply_current_max_ma));
    write_reg(CFG_UPSTREAM, 32'(c.upstream_min_mv));
    write_reg(CFG_VCC, 32'(c.driver_vcc_min_mv));
    write_reg(CFG_PUP_TIMEOUT, c.pup_limit_ms);
    write_reg(CFG_RETRY_DELAY, c.retry_delay_ms);
    write_reg(CFG_RETRY_LIMIT, 32'(c.fault_retry_limit));
    write_reg(CFG_HOLD_ON, c.sync_hold_on_ms);
    write_reg(CFG_HOLD_OFF, c.sync_hold_off_ms);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_model = c;
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    while (pending_ticks.size() != 0 || tick_ch.valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
      offering = 1'b0;
      gap_left = 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        expected_status.push_back(advance_sequencer(offered));
        offering = 1'b0;
        gap_left = $urandom_range(0, tx_gap_max);
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ticks.size() > 0) begin
          offered = pending_ticks.pop_front();
          offering = 1'b1;
          tick_ch.time_ms <= offered.time_ms;
          tick_ch.action <= offered.action;
          tick_ch.supply_current_ma <= offered.supply_current_ma;
          tick_ch.upstream_voltage_mv <= offered.upstream_voltage_mv;
          tick_ch.driver_vcc_mv <= offered.driver_vcc_mv;
          tick_ch.sync_e_valid <= offered.sync_e_valid;
          tick_ch.sync_f_valid <= offered.sync_f_valid;
        end
      end
      tick_ch.valid <= offering;
    end
  end

  // Status monitor and checker.
  always @(posedge clk) begin
    if (rst) begin
      status_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("status with no request outstanding, fsm_state",
                          32'(status_ch.fsm_state), 32'(ST_RESET));
        end else begin
          want = expected_status.pop_front();
          if (status_ch.fsm_state !== want.fsm_state)
            report_mismatch("fsm_state", 32'(status_ch.fsm_state), 32'(want.fsm_state));
          if (status_ch.event_code !== want.event_code)
            report_mismatch("event_code", 32'(status_ch.event_code), 32'(want.event_code));
          if (status_ch.event_valid !== want.event_valid)
            report_mismatch("event_valid", 32'(status_ch.event_valid),
                            32'(want.event_valid));
          if (status_ch.power_enable !== want.power_enable)
            report_mismatch("power_enable", 32'(status_ch.power_enable),
                            32'(want.power_enable));
          if (status_ch.drive_a_enable !== want.drive_a_enable)
            report_mismatch("drive_a_enable", 32'(status_ch.drive_a_enable),
                            32'(want.drive_a_enable));
          if (status_ch.drive_b_enable !== want.drive_b_enable)
            report_mismatch("drive_b_enable", 32'(status_ch.drive_b_enable),
                            32'(want.drive_b_enable));
        end
        status_count++;
        stall_left = $urandom_range(0, rx_stall_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      status_ch.ready <= !receiver_hold && stall_left == 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status words still expected", cycle_count,
               expected_status.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    cfg_we = 1'b0;
    cfg_index = CFG_CURRENT_MAX;
    cfg_data = '0;
    receiver_hold = 1'b0;
    tick_ch.valid = 1'b0;
    tick_ch.time_ms = '0;
    tick_ch.action = ACT_NONE;
    tick_ch.supply_current_ma = '0;
    tick_ch.upstream_voltage_mv = '0;
    tick_ch.driver_vcc_mv = '0;
    tick_ch.sync_e_valid = 1'b0;
    tick_ch.sync_f_valid = 1'b0;
    status_ch.ready = 1'b0;
    cfg_model = CFG_AT_RESET;
    seq_q = ST_RESET;
    entry_ms = '0;
    fault_tally = '0;
    status_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    tx_gap_max = 9;
    rx_stall_max = 9;
    stim_ms = 32'd6000;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk every state and every event but EV_VCC_LOW under the reset configuration.
    queue_tick(32'd5, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd6, ACT_HALT, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd7, ACT_HALT, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd9, ACT_RESET, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd20, ACT_RUN, GOOD_CUR, 10000, 4500, 1'b1, 1'b1);
    // Voltages exactly at their minimum are neither low nor good.
    queue_tick(32'd30, ACT_NONE, GOOD_CUR, 10000, 4500, 1'b1, 1'b1);
    queue_tick(32'd40, ACT_NONE, 1000, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd1040, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd1041, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd1541, ACT_NONE, GOOD_CUR, -1, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd2542, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd2600, ACT_NONE, -65536, 65535, 65535, 1'b1, 1'b1);
    queue_tick(32'd2700, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd2701, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd2752, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b0, 1'b1);
    queue_tick(32'd3253, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd3304, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b0);
    queue_tick(32'd3805, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd4806, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd5807, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd5811, ACT_NONE, GOOD_CUR, 0, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd5812, ACT_RUN, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd5813, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'd5814, ACT_NONE, 1000, -5, -1, 1'b1, 1'b1);
    queue_tick(32'd5815, ACT_RESET, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    // Elapsed time is taken across the 32-bit wrap of the millisecond clock.
    queue_tick(32'hFFFF_FFF0, ACT_RUN, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    queue_tick(32'h0000_0010, ACT_NONE, GOOD_CUR, GOOD_UP, GOOD_VCC, 1'b1, 1'b1);
    wait_until_drained();

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin
          tx_gap_max = 0;
          rx_stall_max = 0;
        end
        1: begin
          tx_gap_max = 9;
          rx_stall_max = 0;
        end
        2: begin
          tx_gap_max = 0;
          rx_stall_max = 9;
        end
        default: begin
          tx_gap_max = 9;
          rx_stall_max = 9;
        end
      endcase
      case (p)
        0: apply_settings(CFG_ALL_LOW);
        1: apply_settings(CFG_ALL_HIGH);
        5: apply_settings(CFG_FAULT_STORM);
        default: apply_settings(random_settings());
      endcase
      if (p == 5) begin
        queue_fault_storm(560);
      end else begin
        queue_random_ticks(p < 2 ? 60 : 75);
        if (p == 3) begin
          // Hold the status side off while requests keep coming, to back up the input.
          @(posedge clk);
          receiver_hold <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          receiver_hold <= 1'b0;
        end
        // The sender pauses here until every outstanding status has come back.
        wait_until_drained();
        queue_random_ticks(p < 2 ? 60 : 75);
      end
      wait_until_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
